// File: rtl/fc3_pkg.sv
// Package for the full 3x3 convolution block.
// Shared constants, register indexes and product types.
// No dependencies.
package fc3_pkg;

  localparam int MAX_LINE  = 2048;
  localparam int COL_W     = $clog2(MAX_LINE);
  localparam int WIDTH_W   = 12;
  localparam int ROWS_W    = 13;
  localparam int ROW_W     = 12;
  localparam int ROW_LIMIT = 4096;
  localparam int COEF_W    = 24;
  localparam int SHIFT_W   = 4;
  localparam int PROD_W    = 17;
  localparam int SUM_W     = 21;
  localparam int TAPS      = 9;
  localparam int ADDR_W    = 5;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd2048;
  localparam logic [ROWS_W-1:0]  ROWS_RESET  = 13'd1024;
  localparam logic [COEF_W-1:0]  COEF_RESET  = 24'h1C1C1C;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd8;

  typedef enum logic [2:0] {
    REG_LINE_WIDTH = 3'd0,
    REG_FRAME_ROWS = 3'd1,
    REG_COEF_TOP   = 3'd2,
    REG_COEF_MID   = 3'd3,
    REG_COEF_BOT   = 3'd4,
    REG_SCALE      = 3'd5
  } reg_idx_t;

  typedef logic [PROD_W-1:0]           prod_t;
  typedef logic [TAPS-1:0][PROD_W-1:0] prod_vec_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } pos_flags_t;

endpackage

// File: rtl/full_2d_convolution_3x3.sv
// Full 3x3 convolution over a streamed, zero-padded 8-bit raster.
// Pipeline: line store read into the stage 1 registers, products registered in stage 2,
// then the adder tree with shift and clamp into the output register.
// Throughput: one word per cycle unless output stalls; the line store is one 2048 x 16 RAM, read at
// acceptance and written back as the word leaves the first stage, with forwarding.
// Reset: counters, window and valids clear; registers take reset values. Depends on fc3_pkg, fc3_sum.
module full_2d_convolution_3x3 (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fc3_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        pixel_valid,
  output logic                        pixel_ready,
  input  logic [7:0]                  pixel,
  output logic                        value_valid,
  input  logic                        value_ready,
  output logic [7:0]                  value,
  output logic                        row_end,
  output logic                        frame_end
);

  // configuration
  logic [fc3_pkg::WIDTH_W-1:0] line_width;
  logic [fc3_pkg::ROWS_W-1:0]  frame_rows;
  logic [fc3_pkg::COEF_W-1:0]  coef_row [3];
  logic [fc3_pkg::SHIFT_W-1:0] scale_shift;
  logic                        cfg_wr;
  fc3_pkg::reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = fc3_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width  <= fc3_pkg::WIDTH_RESET;
      frame_rows  <= fc3_pkg::ROWS_RESET;
      coef_row[0] <= fc3_pkg::COEF_RESET;
      coef_row[1] <= fc3_pkg::COEF_RESET;
      coef_row[2] <= fc3_pkg::COEF_RESET;
      scale_shift <= fc3_pkg::SHIFT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fc3_pkg::REG_LINE_WIDTH: line_width  <= pwdata[fc3_pkg::WIDTH_W-1:0];
        fc3_pkg::REG_FRAME_ROWS: frame_rows  <= pwdata[fc3_pkg::ROWS_W-1:0];
        fc3_pkg::REG_COEF_TOP:   coef_row[0] <= pwdata[fc3_pkg::COEF_W-1:0];
        fc3_pkg::REG_COEF_MID:   coef_row[1] <= pwdata[fc3_pkg::COEF_W-1:0];
        fc3_pkg::REG_COEF_BOT:   coef_row[2] <= pwdata[fc3_pkg::COEF_W-1:0];
        fc3_pkg::REG_SCALE:      scale_shift <= pwdata[fc3_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      fc3_pkg::REG_LINE_WIDTH: prdata = 32'(line_width);
      fc3_pkg::REG_FRAME_ROWS: prdata = 32'(frame_rows);
      fc3_pkg::REG_COEF_TOP:   prdata = 32'(coef_row[0]);
      fc3_pkg::REG_COEF_MID:   prdata = 32'(coef_row[1]);
      fc3_pkg::REG_COEF_BOT:   prdata = 32'(coef_row[2]);
      fc3_pkg::REG_SCALE:      prdata = 32'(scale_shift);
      default:                 prdata = 32'd0;
    endcase
  end

  // pipeline flow control
  logic s1_valid, s2_valid;
  logic s1_adv, s2_adv, accept, out_free;

  assign out_free    = !value_valid || value_ready;
  assign s2_adv      = s2_valid && out_free;
  assign s1_adv      = s1_valid && (!s2_valid || s2_adv);
  assign pixel_ready = !s1_valid || s1_adv;
  assign accept      = pixel_valid && pixel_ready;

  // raster position
  logic [fc3_pkg::COL_W-1:0]   column_count;
  logic [fc3_pkg::ROW_W-1:0]   row_count;
  logic [fc3_pkg::WIDTH_W-1:0] eff_width;
  logic [fc3_pkg::ROWS_W-1:0]  eff_rows;
  fc3_pkg::pos_flags_t         pos;

  always_comb begin
    if (line_width == '0) begin
      eff_width = fc3_pkg::WIDTH_W'(1);
    end else if (line_width > fc3_pkg::WIDTH_W'(fc3_pkg::MAX_LINE)) begin
      eff_width = fc3_pkg::WIDTH_W'(fc3_pkg::MAX_LINE);
    end else begin
      eff_width = line_width;
    end
    if (frame_rows == '0) begin
      eff_rows = fc3_pkg::ROWS_W'(1);
    end else if (frame_rows > fc3_pkg::ROWS_W'(fc3_pkg::ROW_LIMIT)) begin
      eff_rows = fc3_pkg::ROWS_W'(fc3_pkg::ROW_LIMIT);
    end else begin
      eff_rows = frame_rows;
    end
    pos.row_end   = (fc3_pkg::WIDTH_W'(column_count) + fc3_pkg::WIDTH_W'(1)) >= eff_width;
    pos.frame_end = pos.row_end &&
                    ((fc3_pkg::ROWS_W'(row_count) + fc3_pkg::ROWS_W'(1)) >= eff_rows);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (pos.row_end) begin
        column_count <= '0;
        row_count    <= pos.frame_end ? '0 : row_count + fc3_pkg::ROW_W'(1);
      end else begin
        column_count <= column_count + fc3_pkg::COL_W'(1);
      end
    end
  end

  // line store: entry per column, low byte row r-1, high byte row r-2
  logic [15:0] line_store [fc3_pkg::MAX_LINE];
  logic [15:0] mem_q;
  logic [15:0] up;
  logic [15:0] wr_word;

  // stage 1 registers
  logic [7:0]                  s1_px;
  logic [fc3_pkg::COL_W-1:0]   s1_col;
  logic [fc3_pkg::ROW_W-1:0]   s1_row;
  fc3_pkg::pos_flags_t         s1_pos;
  logic                        s1_fwd;
  logic [15:0]                 s1_fwd_data;

  assign up      = s1_fwd ? s1_fwd_data : mem_q;
  assign wr_word = {up[7:0], s1_px};

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_store[s1_col] <= wr_word;
    end
    if (accept) begin
      mem_q <= line_store[column_count];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px       <= pixel;
      s1_col      <= column_count;
      s1_row      <= row_count;
      s1_pos      <= pos;
      s1_fwd      <= s1_adv && (s1_col == column_count);
      s1_fwd_data <= wr_word;
    end
  end

  // window: columns c-1 and c-2 of rows r, r-1, r-2
  logic [7:0] win_a [3];
  logic [7:0] win_b [3];
  logic [7:0] tap   [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win_a[i] <= '0;
        win_b[i] <= '0;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < 3; i++) begin
        win_b[i] <= win_a[i];
        win_a[i] <= tap[i][0];
      end
    end
  end

  // products
  fc3_pkg::prod_vec_t prod;

  always_comb begin
    tap[0][0] = s1_px;
    tap[1][0] = up[7:0];
    tap[2][0] = up[15:8];
    for (int i = 0; i < 3; i++) begin
      tap[i][1] = win_a[i];
      tap[i][2] = win_b[i];
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((s1_row < fc3_pkg::ROW_W'(i)) || (s1_col < fc3_pkg::COL_W'(j))) begin
          prod[3*i+j] = '0;
        end else begin
          prod[3*i+j] = fc3_pkg::PROD_W'($signed(coef_row[i][8*j +: 8]) *
                                         $signed({1'b0, tap[i][j]}));
        end
      end
    end
  end

  // stage 2 registers
  fc3_pkg::prod_vec_t  s2_prod;
  fc3_pkg::pos_flags_t s2_pos;
  logic [7:0]          sum_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_prod <= prod;
      s2_pos  <= s1_pos;
    end
  end

  fc3_sum u_sum (
    .prod  (s2_prod),
    .shift (scale_shift),
    .value (sum_value)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      value_valid <= 1'b0;
    end else if (s2_adv) begin
      value_valid <= 1'b1;
    end else if (value_ready) begin
      value_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      value     <= sum_value;
      row_end   <= s2_pos.row_end;
      frame_end <= s2_pos.frame_end;
    end
  end

endmodule

// File: rtl/fc3_sum.sv
// Adds the nine tap products, shifts and clamps to an 8-bit result.
// Depends on fc3_pkg.
module fc3_sum (
  input  fc3_pkg::prod_vec_t                prod,
  input  logic [fc3_pkg::SHIFT_W-1:0]      shift,
  output logic [7:0]                       value
);

  logic signed [fc3_pkg::SUM_W-1:0] sum;
  logic [fc3_pkg::SUM_W-2:0]        shifted;

  always_comb begin
    sum = '0;
    for (int i = 0; i < fc3_pkg::TAPS; i++) begin
      sum = sum + fc3_pkg::SUM_W'($signed(prod[i]));
    end
    shifted = sum[fc3_pkg::SUM_W-2:0] >> shift;
    if (sum <= 0) begin
      value = 8'd0;
    end else if (shifted > (fc3_pkg::SUM_W-1)'(255)) begin
      value = 8'd255;
    end else begin
      value = shifted[7:0];
    end
  end

endmodule
